### rtl/dktpq_pkg.sv
// Shared types, constants and helpers for the dual-key task priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dktpq_pkg;

    // store size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 16;

    typedef struct packed {
        logic [KEY_W-1:0] tim;
        logic [KEY_W-1:0] urg;
        logic [KEY_W-1:0] id;
    } task_t;

    typedef enum logic [1:0] {
        F_INSERT    = 2'd0,
        F_POP_URG   = 2'd1,
        F_POP_SHORT = 2'd2,
        F_UPDATE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // heap selector
    localparam logic HEAP_URG  = 1'b0;
    localparam logic HEAP_TIME = 1'b1;

    typedef enum logic [1:0] {WS_CUR, WS_BEST, WS_RD, WS_RDURG} wsel_t;
    typedef enum logic [1:0] {CS_HOLD, CS_IN, CS_RD, CS_RDURG} csel_t;
    typedef enum logic [1:0] {BS_HOLD, BS_CUR, BS_RD} bsel_t;

    typedef struct packed {
        logic              heap;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        wsel_t             wr_sel;
        csel_t             cur_sel;
        bsel_t             best_sel;
        logic              in_ld;
        logic              rem_ld;
        logic              out_ld;
        logic              top_zero;
        status_t           status;
        logic [CNT_W-1:0]  count;
    } dp_cmd_t;

    typedef struct packed {
        logic id_match;
        logic rd_better_cur;
        logic rd_better_best;
        logic cur_better_rd;
    } dp_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        task_t            top_short;
        task_t            top_urgent;
        task_t            removed;
        status_t          status;
    } result_t;

    // heap order: max on urgency, min on completion time
    function automatic logic better(input logic heap, input task_t a, input task_t b);
        logic r;
        if (heap == HEAP_URG)
            r = a.urg > b.urg;
        else
            r = a.tim < b.tim;
        return r;
    endfunction

    // heap index 1..CAPACITY to memory address
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] t;
        t = idx - 1'b1;
        return t[ADDR_W-1:0];
    endfunction

endpackage

### rtl/dktpq_datapath.sv
// Datapath: both heap memories, working task registers, comparators, result register.
// Depends on dktpq_pkg; driven by dktpq_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module dktpq_datapath import dktpq_pkg::*;
(
    input  logic             clk,
    input  logic [KEY_W-1:0] in_id,
    input  logic [KEY_W-1:0] in_urg,
    input  logic [KEY_W-1:0] in_tim,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output result_t          res
);

    task_t            mem_urg_reg  [CAPACITY];
    task_t            mem_time_reg [CAPACITY];
    task_t            q_urg_reg;
    task_t            q_time_reg;
    task_t            in_reg;
    task_t            cur_reg;
    task_t            best_reg;
    task_t            rem_reg;
    logic [KEY_W-1:0] key_reg;
    result_t          out_reg;

    task_t rd_task;
    task_t rd_urg;
    task_t wr_data;

    // read data of the heap in use, and a copy with the new urgency
    always_comb
    begin
        rd_task     = (cmd.heap == HEAP_TIME) ? q_time_reg : q_urg_reg;
        rd_urg      = rd_task;
        rd_urg.urg  = in_reg.urg;
    end

    // write data select
    always_comb
    begin
        case (cmd.wr_sel)
            WS_CUR:   wr_data = cur_reg;
            WS_BEST:  wr_data = best_reg;
            WS_RD:    wr_data = rd_task;
            WS_RDURG: wr_data = rd_urg;
            default:  wr_data = cur_reg;
        endcase
    end

    // heap memories, registered read of the same slot in both
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            q_urg_reg  <= mem_urg_reg[cmd.rd_addr];
            q_time_reg <= mem_time_reg[cmd.rd_addr];
        end
        if (cmd.wr_en && cmd.heap == HEAP_URG)
            mem_urg_reg[cmd.wr_addr] <= wr_data;
        if (cmd.wr_en && cmd.heap == HEAP_TIME)
            mem_time_reg[cmd.wr_addr] <= wr_data;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_ld)
        begin
            in_reg.id  <= in_id;
            in_reg.urg <= in_urg;
            in_reg.tim <= in_tim;
            key_reg    <= in_id;
            rem_reg    <= '0;
        end
        if (cmd.rem_ld)
        begin
            rem_reg <= rd_task;
            key_reg <= rd_task.id;
        end
        case (cmd.cur_sel)
            CS_IN:    cur_reg <= in_reg;
            CS_RD:    cur_reg <= rd_task;
            CS_RDURG: cur_reg <= rd_urg;
            default:  cur_reg <= cur_reg;
        endcase
        case (cmd.best_sel)
            BS_CUR:  best_reg <= cur_reg;
            BS_RD:   best_reg <= rd_task;
            default: best_reg <= best_reg;
        endcase
    end

    // result register, tops read from slot 1 of both heaps
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_reg.status     <= cmd.status;
            out_reg.removed    <= rem_reg;
            out_reg.top_urgent <= cmd.top_zero ? '0 : q_urg_reg;
            out_reg.top_short  <= cmd.top_zero ? '0 : q_time_reg;
            out_reg.count      <= cmd.count;
        end
    end

    // comparisons for search and sifting
    always_comb
    begin
        stat.id_match       = rd_task.id == key_reg;
        stat.rd_better_cur  = better(cmd.heap, rd_task, cur_reg);
        stat.rd_better_best = better(cmd.heap, rd_task, best_reg);
        stat.cur_better_rd  = better(cmd.heap, cur_reg, rd_task);
    end

    assign res = out_reg;

endmodule

### rtl/dktpq_ctrl.sv
// Controller: sequences id search, sift up and sift down over the two heaps.
// Depends on dktpq_pkg; commands dktpq_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module dktpq_ctrl import dktpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_func,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_POP_RD, S_FIND_RD, S_FIND_CMP,
        S_SU_CHK, S_SU_CMP, S_SD_CHK, S_SD_L, S_SD_R, S_SD_DEC,
        S_NEXT, S_POP_LAST, S_RM2_LAST, S_UPD_T, S_UPD_U, S_TOP, S_TOP2
    } state_t;

    typedef enum logic [3:0] {
        P_INS_FIND, P_INS_SU0, P_INS_SU1, P_POP_FIND, P_POP_RM1,
        P_POP_RM2_SU, P_POP_RM2_SD, P_UPD_FIND0, P_UPD_FIND1, P_UPD_SU, P_UPD_SD
    } phase_t;

    state_t           st_reg, st_next;
    phase_t           ph_reg, ph_next;
    func_t            func_reg, func_next;
    status_t          status_reg, status_next;
    logic             h_reg, h_next;
    logic             moved_reg, moved_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] bi_reg, bi_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic [IDX_W-1:0] n_reg, n_next;

    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] np1;
    logic [IDX_W:0]   lw;

    assign nm1 = n_reg - 1'b1;
    assign np1 = n_reg + 1'b1;
    assign lw  = {i_reg, 1'b0};

    // next state and datapath commands
    always_comb
    begin
        st_next        = st_reg;
        ph_next        = ph_reg;
        func_next      = func_reg;
        status_next    = status_reg;
        h_next         = h_reg;
        moved_next     = moved_reg;
        i_next         = i_reg;
        lim_next       = lim_reg;
        c_next         = c_reg;
        bi_next        = bi_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        cmd          = '0;
        cmd.heap     = h_reg;
        cmd.wr_sel   = WS_CUR;
        cmd.cur_sel  = CS_HOLD;
        cmd.best_sel = BS_HOLD;
        cmd.status   = status_reg;
        cmd.count    = CNT_W'(n_reg);

        case (st_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_ld   = 1'b1;
                    func_next   = func_t'(in_func);
                    status_next = ST_OK;
                    st_next     = S_START;
                end
            end

            S_START:
            begin
                case (func_reg)
                    F_INSERT:
                    begin
                        h_next  = HEAP_URG;
                        i_next  = IDX_W'(1);
                        ph_next = P_INS_FIND;
                        st_next = S_FIND_RD;
                    end
                    F_UPDATE:
                    begin
                        h_next  = HEAP_URG;
                        i_next  = IDX_W'(1);
                        ph_next = P_UPD_FIND0;
                        st_next = S_FIND_RD;
                    end
                    default:
                    begin
                        if (n_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            st_next     = S_TOP;
                        end
                        else
                        begin
                            h_next      = (func_reg == F_POP_URG) ? HEAP_URG : HEAP_TIME;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = slot_addr(IDX_W'(1));
                            st_next     = S_POP_RD;
                        end
                    end
                endcase
            end

            // take the root, then search its id in the other heap
            S_POP_RD:
            begin
                cmd.rem_ld = 1'b1;
                h_next     = ~h_reg;
                i_next     = IDX_W'(1);
                ph_next    = P_POP_FIND;
                st_next    = S_FIND_RD;
            end

            // linear id search over slots 1..count
            S_FIND_RD:
            begin
                if (i_reg > n_reg)
                begin
                    found_next = '0;
                    st_next    = S_NEXT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = slot_addr(i_reg);
                    st_next     = S_FIND_CMP;
                end
            end

            S_FIND_CMP:
            begin
                if (stat.id_match)
                begin
                    found_next = i_reg;
                    st_next    = S_NEXT;
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_FIND_RD;
                end
            end

            // sift up with a hole: parents move down until cur settles
            S_SU_CHK:
            begin
                if (i_reg == IDX_W'(1))
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = slot_addr(i_reg);
                    cmd.wr_sel  = WS_CUR;
                    st_next     = S_NEXT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = slot_addr(i_reg >> 1);
                    st_next     = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = slot_addr(i_reg);
                if (stat.cur_better_rd)
                begin
                    cmd.wr_sel = WS_RD;
                    i_next     = i_reg >> 1;
                    moved_next = 1'b1;
                    st_next    = S_SU_CHK;
                end
                else
                begin
                    cmd.wr_sel = WS_CUR;
                    st_next    = S_NEXT;
                end
            end

            // sift down with a hole: left child first, right only if strictly better
            S_SD_CHK:
            begin
                if (lw > {1'b0, lim_reg})
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = slot_addr(i_reg);
                    cmd.wr_sel  = WS_CUR;
                    st_next     = S_NEXT;
                end
                else
                begin
                    c_next      = lw[IDX_W-1:0];
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = slot_addr(lw[IDX_W-1:0]);
                    st_next     = S_SD_L;
                end
            end

            S_SD_L:
            begin
                if (stat.rd_better_cur)
                begin
                    cmd.best_sel = BS_RD;
                    bi_next      = c_reg;
                end
                else
                begin
                    cmd.best_sel = BS_CUR;
                    bi_next      = i_reg;
                end
                if (c_reg < lim_reg)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = slot_addr(c_reg + 1'b1);
                    st_next     = S_SD_R;
                end
                else
                begin
                    st_next = S_SD_DEC;
                end
            end

            S_SD_R:
            begin
                if (stat.rd_better_best)
                begin
                    cmd.best_sel = BS_RD;
                    bi_next      = c_reg + 1'b1;
                end
                st_next = S_SD_DEC;
            end

            S_SD_DEC:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = slot_addr(i_reg);
                if (bi_reg == i_reg)
                begin
                    cmd.wr_sel = WS_CUR;
                    st_next    = S_NEXT;
                end
                else
                begin
                    cmd.wr_sel = WS_BEST;
                    i_next     = bi_reg;
                    st_next    = S_SD_CHK;
                end
            end

            // operation sequencing between search and sift steps
            S_NEXT:
            begin
                case (ph_reg)
                    P_INS_FIND:
                    begin
                        if (found_reg != '0)
                        begin
                            status_next = ST_DUP;
                            st_next     = S_TOP;
                        end
                        else if (n_reg >= IDX_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            st_next     = S_TOP;
                        end
                        else
                        begin
                            n_next      = np1;
                            cmd.cur_sel = CS_IN;
                            h_next      = HEAP_URG;
                            i_next      = np1;
                            ph_next     = P_INS_SU0;
                            st_next     = S_SU_CHK;
                        end
                    end
                    P_INS_SU0:
                    begin
                        cmd.cur_sel = CS_IN;
                        h_next      = HEAP_TIME;
                        i_next      = n_reg;
                        ph_next     = P_INS_SU1;
                        st_next     = S_SU_CHK;
                    end
                    P_POP_FIND:
                    begin
                        k_next      = found_reg;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = slot_addr(n_reg);
                        h_next      = ~h_reg;
                        st_next     = S_POP_LAST;
                    end
                    P_POP_RM1:
                    begin
                        if (k_reg != '0)
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = slot_addr(n_reg);
                            h_next      = ~h_reg;
                            st_next     = S_RM2_LAST;
                        end
                        else
                        begin
                            n_next  = nm1;
                            st_next = S_TOP;
                        end
                    end
                    P_POP_RM2_SU:
                    begin
                        if (moved_reg)
                        begin
                            n_next  = nm1;
                            st_next = S_TOP;
                        end
                        else
                        begin
                            i_next   = k_reg;
                            lim_next = nm1;
                            ph_next  = P_POP_RM2_SD;
                            st_next  = S_SD_CHK;
                        end
                    end
                    P_POP_RM2_SD:
                    begin
                        n_next  = nm1;
                        st_next = S_TOP;
                    end
                    P_UPD_FIND0:
                    begin
                        if (found_reg == '0)
                        begin
                            status_next = ST_NOTFOUND;
                            st_next     = S_TOP;
                        end
                        else
                        begin
                            k_next  = found_reg;
                            h_next  = HEAP_TIME;
                            i_next  = IDX_W'(1);
                            ph_next = P_UPD_FIND1;
                            st_next = S_FIND_RD;
                        end
                    end
                    P_UPD_FIND1:
                    begin
                        cmd.rd_en = 1'b1;
                        if (found_reg != '0)
                        begin
                            cmd.rd_addr = slot_addr(found_reg);
                            st_next     = S_UPD_T;
                        end
                        else
                        begin
                            cmd.rd_addr = slot_addr(k_reg);
                            h_next      = HEAP_URG;
                            st_next     = S_UPD_U;
                        end
                    end
                    P_UPD_SU:
                    begin
                        if (moved_reg)
                            st_next = S_TOP;
                        else
                        begin
                            i_next   = k_reg;
                            lim_next = n_reg;
                            ph_next  = P_UPD_SD;
                            st_next  = S_SD_CHK;
                        end
                    end
                    default:
                    begin
                        st_next = S_TOP;
                    end
                endcase
            end

            // last entry fills the root of the popped heap
            S_POP_LAST:
            begin
                cmd.cur_sel = CS_RD;
                i_next      = IDX_W'(1);
                lim_next    = nm1;
                ph_next     = P_POP_RM1;
                st_next     = S_SD_CHK;
            end

            // last entry fills the vacated slot of the other heap
            S_RM2_LAST:
            begin
                cmd.cur_sel = CS_RD;
                if (k_reg <= nm1)
                begin
                    i_next     = k_reg;
                    moved_next = 1'b0;
                    ph_next    = P_POP_RM2_SU;
                    st_next    = S_SU_CHK;
                end
                else
                begin
                    n_next  = nm1;
                    st_next = S_TOP;
                end
            end

            // time heap copy takes the new urgency in place
            S_UPD_T:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = slot_addr(found_reg);
                cmd.wr_sel  = WS_RDURG;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = slot_addr(k_reg);
                h_next      = HEAP_URG;
                st_next     = S_UPD_U;
            end

            S_UPD_U:
            begin
                cmd.cur_sel = CS_RDURG;
                i_next      = k_reg;
                moved_next  = 1'b0;
                ph_next     = P_UPD_SU;
                st_next     = S_SU_CHK;
            end

            S_TOP:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = slot_addr(IDX_W'(1));
                st_next     = S_TOP2;
            end

            // load the result once the output register is free
            S_TOP2:
            begin
                cmd.top_zero = n_reg == '0;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_ld     = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            ph_reg        <= P_INS_FIND;
            func_reg      <= F_INSERT;
            status_reg    <= ST_OK;
            h_reg         <= HEAP_URG;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            lim_reg       <= '0;
            c_reg         <= '0;
            bi_reg        <= '0;
            k_reg         <= '0;
            found_reg     <= '0;
            n_reg         <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            ph_reg        <= ph_next;
            func_reg      <= func_next;
            status_reg    <= status_next;
            h_reg         <= h_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            lim_reg       <= lim_next;
            c_reg         <= c_next;
            bi_reg        <= bi_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            n_reg         <= n_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/dual_key_task_priority_queue.sv
// Top level of the dual-key task priority queue: stream ports, controller and datapath.
// Depends on dktpq_pkg, dktpq_ctrl and dktpq_datapath.
`timescale 1ns / 1ps
//
// channel   direction  width  contents
// s_axis    in         48+2   one operation on the task set
// m_axis    out        160    status, removed task, both tops, count
//
// One operation at a time. An id search reads the held tasks one by one, and
// each heap level of a sift reads a parent or up to two children, all on the
// single read port of the memories. Reset clears the controller state and the
// count only; heap slots are never used before written.
// The result register holds while m_axis_tready is low and the next
// transaction is taken as soon as the result is loaded.

module dual_key_task_priority_queue import dktpq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // task_id, urgency, completion_time
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // status, removed_id, removed_urgency,
                                         // removed_time, top_urgent_id,
                                         // top_urgent_urgency, top_urgent_time,
                                         // top_short_id, top_short_urgency,
                                         // top_short_time, task_count, zero pad
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  res;

    dktpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dktpq_datapath u_dp (
        .clk    (clk),
        .in_id  (s_axis_tdata[15:0]),
        .in_urg (s_axis_tdata[31:16]),
        .in_tim (s_axis_tdata[47:32]),
        .cmd    (cmd),
        .stat   (stat),
        .res    (res)
    );

    // result packing, first field lowest
    assign m_axis_tdata = {
        6'd0,
        res.count,
        res.top_short.tim, res.top_short.urg, res.top_short.id,
        res.top_urgent.tim, res.top_urgent.urg, res.top_urgent.id,
        res.removed.tim, res.removed.urg, res.removed.id,
        res.status
    };

endmodule

### rtl/dktpq_checker.sv
// Port-level checks for the dual-key task priority queue, bound to the top level.
// Depends on dktpq_pkg and dual_key_task_priority_queue.
`timescale 1ns / 1ps

module dktpq_checker import dktpq_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [47:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

    // status code and count in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4 && m_axis_tdata[153:147] <= CNT_W'(CAPACITY))
    else $error("status or count out of range");

    // empty queue shows zero tops
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[153:147] == '0 |-> m_axis_tdata[146:51] == '0)
    else $error("tops not zero on empty queue");

    // failed operations remove nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[50:3] == '0)
    else $error("removed task on failed operation");

    // full status comes only with the count at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == 3'd4 |-> m_axis_tdata[153:147] == CNT_W'(CAPACITY))
    else $error("full status with spare room");

endmodule

bind dual_key_task_priority_queue dktpq_checker u_chk (.*);
